### rtl/core/fal_pkg.sv
// Shared constants for the failed-attempt lockout block: table sizes, index widths,
// request kinds and configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package fal_pkg;

    localparam int TRACK_ENTRIES = 64;
    localparam int BLOCK_ENTRIES = 16;

    localparam int TIDX_W = $clog2(TRACK_ENTRIES);
    localparam int BIDX_W = $clog2(BLOCK_ENTRIES);
    localparam int SCAN_W = (TIDX_W > BIDX_W) ? TIDX_W : BIDX_W;
    // Matching failures plus the one being recorded.
    localparam int CNT_W  = $clog2(TRACK_ENTRIES + 2);

    localparam int KEY_W   = 32;
    localparam int TIME_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int LIMIT_W = 4;
    localparam int SEC_W   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SECS   = 2'd2;

    localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST  = 4'd3;
    localparam logic [SEC_W-1:0]   WINDOW_SECS_RST = 16'd20;
    localparam logic [SEC_W-1:0]   BLOCK_SECS_RST  = 16'd300;

    localparam logic [FUNC_W-1:0] FUNC_OTHER   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FAIL    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SUCCESS = 2'd2;

endpackage

### rtl/core/failed_attempt_lockout.sv
// Failed-attempt lockout filter: a sequencer that scans the block table and the
// failure track table through one shared age and key compare unit. Uses fal_pkg.
`timescale 1ns / 1ps

// How the block is used.
// Input channel s_axis: one request per handshake. tdata carries the source key
// in bits 31:0 and the event time in seconds in bits 63:32; tuser carries the
// kind (other, failed login, successful login). Times must not decrease.
// Output channel m_axis: exactly one result per request. tdata bit 0 is blocked,
// bit 1 is block_started, bit 2 is table_full, bits 7:3 are zero.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 fail
// limit, 1 window seconds, 2 block seconds); other indexes are ignored. Write
// only while the block is idle.
// Timing: a request is taken only in the idle state. The block table is scanned
// first, one entry per cycle through registered memory reads. A blocked source
// finishes there. Otherwise the track table is scanned the same way, followed by
// the write state and the output state that loads the output register. The next
// request is taken only after the result has been loaded; the single compare
// unit is why the tables are scanned one entry at a time.
// Reset clears all valid bits, the registers return to 3, 20 and 300 seconds, and
// the output is empty; no clearing pass is needed. A result waits in the output
// register while the next request is accepted; if the receiver still stalls
// when the next result is ready, the sequencer holds until the register frees.

module failed_attempt_lockout
    import fal_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // source_key[31:0], time_seconds[63:32]
    input  logic [FUNC_W-1:0]     s_axis_tuser,  // func[1:0]
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // blocked[0], block_started[1], table_full[2]
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BSCAN = 3'd1;
    localparam logic [2:0] S_TSCAN = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [SCAN_W-1:0] B_LAST = SCAN_W'(BLOCK_ENTRIES - 1);
    localparam logic [SCAN_W-1:0] T_LAST = SCAN_W'(TRACK_ENTRIES - 1);

    // Configuration registers.
    logic [LIMIT_W-1:0] r_fail_limit;
    logic [SEC_W-1:0]   r_window_secs;
    logic [SEC_W-1:0]   r_block_secs;

    // Request under work.
    logic [KEY_W-1:0]   r_key;
    logic [TIME_W-1:0]  r_now;
    logic [FUNC_W-1:0]  r_func;

    // Sequencer.
    logic [2:0]         r_state;
    logic [SCAN_W-1:0]  r_idx;
    logic               r_issue;
    logic [SCAN_W-1:0]  r_chk_idx;
    logic               r_chk_vld;

    // Tables. Key and time live in memories, valid bits in flip-flops.
    logic [KEY_W-1:0]   r_tkey_mem  [TRACK_ENTRIES];
    logic [TIME_W-1:0]  r_ttime_mem [TRACK_ENTRIES];
    logic [KEY_W-1:0]   r_bkey_mem  [BLOCK_ENTRIES];
    logic [TIME_W-1:0]  r_btime_mem [BLOCK_ENTRIES];
    logic [TRACK_ENTRIES-1:0] r_tvalid;
    logic [BLOCK_ENTRIES-1:0] r_bvalid;
    logic [KEY_W-1:0]   r_tkey_rd;
    logic [TIME_W-1:0]  r_ttime_rd;
    logic [KEY_W-1:0]   r_bkey_rd;
    logic [TIME_W-1:0]  r_btime_rd;

    // Scan results.
    logic               r_blocked;
    logic               r_bfree_fnd;
    logic [BIDX_W-1:0]  r_bfree_idx;
    logic               r_tfree_fnd;
    logic [TIDX_W-1:0]  r_tfree_idx;
    logic [CNT_W-1:0]   r_count;
    logic               r_started;
    logic               r_full;

    // Output register.
    logic               r_out_vld;
    logic [2:0]         r_out_bits;

    // Shared compare unit signals.
    logic [KEY_W-1:0]   w_rd_key;
    logic [TIME_W-1:0]  w_rd_time;
    logic [SEC_W-1:0]   w_limit;
    logic [TIME_W:0]    w_diff;
    logic               w_expire;
    logic               w_key_eq;
    logic               w_entry_vld;
    logic               w_live;
    logic               w_free;
    logic [BIDX_W-1:0]  w_bidx;
    logic [TIDX_W-1:0]  w_tidx;
    logic [SCAN_W-1:0]  w_last;
    logic [CNT_W-1:0]   w_total;
    logic               w_out_free;

    assign w_bidx = r_chk_idx[BIDX_W-1:0];
    assign w_tidx = r_chk_idx[TIDX_W-1:0];

    // One age and key compare, fed by whichever table is being scanned.
    always_comb begin
        if (r_state == S_BSCAN) begin
            w_rd_key    = r_bkey_rd;
            w_rd_time   = r_btime_rd;
            w_limit     = r_block_secs;
            w_entry_vld = r_bvalid[w_bidx];
            w_last      = B_LAST;
        end else begin
            w_rd_key    = r_tkey_rd;
            w_rd_time   = r_ttime_rd;
            w_limit     = r_window_secs;
            w_entry_vld = r_tvalid[w_tidx];
            w_last      = T_LAST;
        end
    end

    // When time appears to go backwards the subtraction borrows, so the borrow bit
    // alone rules out expiry.
    assign w_diff   = {1'b0, r_now} - {1'b0, w_rd_time};
    assign w_expire = !w_diff[TIME_W] &&
                      (w_diff[TIME_W-1:0] > {{(TIME_W-SEC_W){1'b0}}, w_limit});
    assign w_key_eq = (w_rd_key == r_key);
    assign w_live   = w_entry_vld && !w_expire;
    assign w_free   = !w_live;

    // Failures of this source, counting the one about to be stored.
    assign w_total = r_count + CNT_W'(r_tfree_fnd);

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b0, r_out_bits};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_limit  <= FAIL_LIMIT_RST;
            r_window_secs <= WINDOW_SECS_RST;
            r_block_secs  <= BLOCK_SECS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FAIL_LIMIT:  r_fail_limit  <= i_cfg_data[LIMIT_W-1:0];
                REG_WINDOW_SECS: r_window_secs <= i_cfg_data;
                REG_BLOCK_SECS:  r_block_secs  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Track table memory: one read address from the scan counter, one write in
    // the write state.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_func == FUNC_FAIL && r_tfree_fnd) begin
            r_tkey_mem[r_tfree_idx]  <= r_key;
            r_ttime_mem[r_tfree_idx] <= r_now;
        end
        r_tkey_rd  <= r_tkey_mem[r_idx[TIDX_W-1:0]];
        r_ttime_rd <= r_ttime_mem[r_idx[TIDX_W-1:0]];
    end

    // Block table memory.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_func == FUNC_FAIL && w_total >= CNT_W'(r_fail_limit)
                && r_bfree_fnd) begin
            r_bkey_mem[r_bfree_idx]  <= r_key;
            r_btime_mem[r_bfree_idx] <= r_now;
        end
        r_bkey_rd  <= r_bkey_mem[r_idx[BIDX_W-1:0]];
        r_btime_rd <= r_btime_mem[r_idx[BIDX_W-1:0]];
    end

    // Request capture; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_key  <= s_axis_tdata[KEY_W-1:0];
            r_now  <= s_axis_tdata[KEY_W+TIME_W-1:KEY_W];
            r_func <= s_axis_tuser;
        end
    end

    // Sequencer, valid bits and scan results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_issue   <= 1'b0;
            r_chk_vld <= 1'b0;
            r_chk_idx <= '0;
            r_tvalid  <= '0;
            r_bvalid  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            // Scan pipeline: issue a read, check it the next cycle.
            r_chk_vld <= r_issue;
            r_chk_idx <= r_idx;
            if (r_issue) begin
                if (r_idx == w_last) begin
                    r_issue <= 1'b0;
                    r_idx   <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state     <= S_BSCAN;
                        r_idx       <= '0;
                        r_issue     <= 1'b1;
                        r_blocked   <= 1'b0;
                        r_bfree_fnd <= 1'b0;
                        r_bfree_idx <= '0;
                        r_tfree_fnd <= 1'b0;
                        r_tfree_idx <= '0;
                        r_count     <= '0;
                        r_started   <= 1'b0;
                        r_full      <= 1'b0;
                    end
                end

                S_BSCAN: begin
                    if (r_chk_vld) begin
                        if (r_bvalid[w_bidx] && w_expire) begin
                            r_bvalid[w_bidx] <= 1'b0;
                        end
                        if (w_live && w_key_eq) begin
                            r_blocked <= 1'b1;
                        end
                        if (w_free && !r_bfree_fnd) begin
                            r_bfree_fnd <= 1'b1;
                            r_bfree_idx <= w_bidx;
                        end
                        if (r_chk_idx == B_LAST) begin
                            // A blocked source, including one whose live block is found in
                            // this last entry, skips the track table.
                            if (r_blocked || (w_live && w_key_eq)) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_TSCAN;
                                r_issue <= 1'b1;
                                r_idx   <= '0;
                            end
                        end
                    end
                end

                S_TSCAN: begin
                    if (r_chk_vld) begin
                        if (r_tvalid[w_tidx] && w_expire) begin
                            r_tvalid[w_tidx] <= 1'b0;
                        end
                        if (w_live && w_key_eq) begin
                            if (r_func == FUNC_SUCCESS) begin
                                r_tvalid[w_tidx] <= 1'b0;
                            end
                            r_count <= r_count + 1'b1;
                        end
                        if (w_free && !r_tfree_fnd) begin
                            r_tfree_fnd <= 1'b1;
                            r_tfree_idx <= w_tidx;
                        end
                        if (r_chk_idx == T_LAST) begin
                            r_state <= S_WRITE;
                        end
                    end
                end

                S_WRITE: begin
                    if (r_func == FUNC_FAIL) begin
                        if (r_tfree_fnd) begin
                            r_tvalid[r_tfree_idx] <= 1'b1;
                        end else begin
                            r_full <= 1'b1;
                        end
                        if (w_total >= CNT_W'(r_fail_limit)) begin
                            if (r_bfree_fnd) begin
                                r_bvalid[r_bfree_idx] <= 1'b1;
                                r_started             <= 1'b1;
                            end else begin
                                r_full <= 1'b1;
                            end
                        end
                    end
                    r_state <= S_OUT;
                end

                S_OUT: begin
                    if (w_out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_bits <= {r_full, r_started, r_blocked};
                        r_state    <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
